/* src/etb_pkg.sv */
package etb_pkg;

    localparam int VERTEX_W     = 10;
    localparam int RANK_W       = 10;
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);

    typedef logic [VERTEX_W-1:0] vertex_t;
    typedef logic [RANK_W-1:0]   rank_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    // one ancestor store entry: valid flag plus ancestor label
    typedef struct packed {
        logic    valid;
        vertex_t label;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } state_t;

    function automatic logic in_range(input vertex_t v);
        return 32'(v) < MAX_VERTICES;
    endfunction

endpackage

/* src/elimination_tree_builder.sv */
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    row_vertex, row_rank, neighbor_vertex, neighbor_rank
// m_       out        m_valid/m_ready    child_vertex, parent_vertex
//
// A pair is taken while the block is idle; a pair whose neighbour does not rank below the
// row ends there. Otherwise the walk visits the ancestor entries one by one, pointing each
// at the row, until it reaches a root or an entry that already names the row.
// After reset a clearing pass empties the ancestor memory; s_ready stays low
// meanwhile. A result waits in the output register; a further pair is taken while it
// waits, and only a walk that must emit holds until the slot frees.
module elimination_tree_builder (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  etb_pkg::vertex_t s_row_vertex,
    input  etb_pkg::rank_t   s_row_rank,
    input  etb_pkg::vertex_t s_neighbor_vertex,
    input  etb_pkg::rank_t   s_neighbor_rank,
    output logic            m_valid,
    input  logic            m_ready,
    output etb_pkg::vertex_t m_child_vertex,
    output etb_pkg::vertex_t m_parent_vertex
);
    import etb_pkg::*;

    state_t  state_reg, state_next;
    addr_t   clr_reg, clr_next;
    addr_t   cur_reg, cur_next;
    vertex_t row_reg, row_next;

    logic    out_valid_reg;
    vertex_t out_child_reg;
    vertex_t out_parent_reg;
    logic    out_load;
    logic    out_free;

    entry_t  mem [MAX_VERTICES];
    entry_t  rd_data_reg;
    addr_t   rd_addr;
    logic    we;
    addr_t   wr_addr;
    entry_t  wr_data;

    logic    walk_ok;

    assign out_free = !out_valid_reg || m_ready;
    assign walk_ok  = (s_neighbor_rank < s_row_rank) && in_range(s_row_vertex)
                      && in_range(s_neighbor_vertex);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == addr_t'(MAX_VERTICES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && walk_ok) state_next = ST_WALK;
            end
            ST_WALK: begin
                if (!rd_data_reg.valid) begin
                    if (out_free) state_next = ST_IDLE;
                end else if (rd_data_reg.label == row_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_ready  = 1'b0;
        rd_addr  = cur_reg;
        we       = 1'b0;
        wr_addr  = cur_reg;
        wr_data  = '{valid: 1'b1, label: row_reg};
        out_load = 1'b0;
        clr_next = clr_reg;
        cur_next = cur_reg;
        row_next = row_reg;
        case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '{valid: 1'b0, label: '0};
                clr_next = clr_reg + addr_t'(1);
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                rd_addr  = s_neighbor_vertex[ADDR_W-1:0];
                cur_next = s_neighbor_vertex[ADDR_W-1:0];
                row_next = s_row_vertex;
            end
            ST_WALK: begin
                if (!rd_data_reg.valid) begin
                    // root reached: hang it under the row and emit the link
                    if (out_free) begin
                        we       = 1'b1;
                        out_load = 1'b1;
                    end
                end else if (rd_data_reg.label != row_reg) begin
                    // compress the path and advance to the old ancestor
                    we       = 1'b1;
                    rd_addr  = rd_data_reg.label[ADDR_W-1:0];
                    cur_next = rd_data_reg.label[ADDR_W-1:0];
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        row_reg <= row_next;
        if (out_load) begin
            out_child_reg  <= vertex_t'(cur_reg);
            out_parent_reg <= row_reg;
        end
    end

    // ancestor memory, forward a write to a read of the same entry
    always_ff @(posedge aclk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (we && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_child_vertex  = out_child_reg;
    assign m_parent_vertex = out_parent_reg;

endmodule

/* src/elimination_tree_builder_checker.sv */
module elimination_tree_builder_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input etb_pkg::vertex_t s_row_vertex,
    input etb_pkg::rank_t   s_row_rank,
    input etb_pkg::vertex_t s_neighbor_vertex,
    input etb_pkg::rank_t   s_neighbor_rank,
    input logic            m_valid,
    input logic            m_ready,
    input etb_pkg::vertex_t m_child_vertex,
    input etb_pkg::vertex_t m_parent_vertex
);
    import etb_pkg::*;

    // a waiting item holds on the input
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_row_vertex) && $stable(s_row_rank)
                                && $stable(s_neighbor_vertex) && $stable(s_neighbor_rank))
        else $error("input item changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_child_vertex)
                                && $stable(m_parent_vertex))
        else $error("result changed while stalled");

    // reset starts the clearing pass with nothing shown
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block ready or valid right after reset");

    // a pair that does not walk leaves the block ready
    a_drop_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_neighbor_rank >= s_row_rank) |=> s_ready)
        else $error("dropped item blocked the input");

    // a pair that walks occupies the block, dropping s_ready in the next cycle
    a_walk_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_neighbor_rank < s_row_rank) |=> !s_ready)
        else $error("walking item did not hold the input");

endmodule

bind elimination_tree_builder elimination_tree_builder_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_row_vertex     (s_row_vertex),
    .s_row_rank       (s_row_rank),
    .s_neighbor_vertex(s_neighbor_vertex),
    .s_neighbor_rank  (s_neighbor_rank),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_child_vertex   (m_child_vertex),
    .m_parent_vertex  (m_parent_vertex)
);
